FILE: hw/rtl/csa_pkg.sv
// Shared definitions for the contiguous slot allocator: operation and
// status codes, the default pool size, and the controller/datapath link types.
// No dependencies.
package csa_pkg;

    localparam int CSA_SLOT_COUNT = 40;

    localparam int FUNC_W   = 2;
    localparam int BASE_W   = 8;
    localparam int LEN_W    = 8;
    localparam int GBASE_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOROOM = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // latch the incoming request
        logic exec;   // decode, apply free or clear, preset the result
        logic step;   // examine one slot of the first-fit scan
        logic mark;   // set the found run as in use
        logic post;   // move the result into the output register
    } csa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_needed;  // latched request is a well-formed allocate
        logic found;        // current scan step completes a free run
        logic last;         // current scan step is at the top slot
    } csa_sts_t;

endpackage

FILE: hw/rtl/csa_ctrl.sv
// Sequencer for the contiguous slot allocator: request handshake, scan
// control and output valid. Depends on csa_pkg.
module csa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  csa_pkg::csa_sts_t sts,
    output csa_pkg::csa_cmd_t cmd
);
    import csa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_MARK = 5'b01000,
        S_POST = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.scan_needed ? S_SCAN : S_POST;
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.found)
                    state_next = S_MARK;
                else if (sts.last)
                    state_next = S_POST;
            end
            S_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.post)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/csa_datapath.sv
// Datapath for the contiguous slot allocator: in-use map, first-fit scan
// registers, result and output registers. Depends on csa_pkg.
module csa_datapath #(
    parameter int SLOT_COUNT = csa_pkg::CSA_SLOT_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [csa_pkg::FUNC_W-1:0]   func,
    input  logic [csa_pkg::BASE_W-1:0]   base_slot,
    input  logic [csa_pkg::LEN_W-1:0]    run_length,
    input  csa_pkg::csa_cmd_t            cmd,
    output csa_pkg::csa_sts_t            sts,
    output logic                         granted,
    output logic [csa_pkg::GBASE_W-1:0]  granted_base,
    output logic [csa_pkg::STATUS_W-1:0] status
);
    import csa_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int SW = BASE_W + 1;
    localparam logic [SW-1:0] SLOTS_EXT = SW'(SLOT_COUNT);

    logic [FUNC_W-1:0]     func_reg;
    logic [BASE_W-1:0]     base_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [SLOT_COUNT-1:0] map_reg, map_next;
    logic [IW-1:0]         idx_reg;
    logic [CW-1:0]         run_cnt_reg, run_cnt_next;
    logic [IW-1:0]         run_start_reg;
    logic [IW-1:0]         found_base_reg;
    logic                  res_granted_reg;
    logic [GBASE_W-1:0]    res_base_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic                  out_granted_reg;
    logic [GBASE_W-1:0]    out_base_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic                  len_ok;
    logic                  alloc_ok;
    logic                  free_ok;
    logic                  slot_free;
    logic [IW-1:0]         base_now;
    logic [SW-1:0]         free_end;

    // bits lo .. lo+len-1 of the pool
    function automatic logic [SLOT_COUNT-1:0] run_mask(input logic [SW-1:0] lo,
                                                       input logic [SW-1:0] len);
        logic [SLOT_COUNT-1:0] m;
        logic [SW-1:0]         hi;
        hi = lo + len;
        for (int k = 0; k < SLOT_COUNT; k++)
            m[k] = (SW'(k) >= lo) && (SW'(k) < hi);
        return m;
    endfunction

    assign len_ok   = (len_reg != '0) && ({1'b0, len_reg} <= SLOTS_EXT);
    assign alloc_ok = (func_reg == FUNC_ALLOC) && len_ok;
    assign free_end = {1'b0, base_reg} + {1'b0, len_reg};
    assign free_ok  = (func_reg == FUNC_FREE) && (len_reg != '0)
                      && ({1'b0, base_reg} < SLOTS_EXT) && (free_end <= SLOTS_EXT);

    assign slot_free    = !map_reg[idx_reg];
    assign run_cnt_next = slot_free ? CW'(run_cnt_reg + 1'b1) : '0;
    assign base_now     = (run_cnt_reg == '0) ? idx_reg : run_start_reg;

    assign sts.scan_needed = alloc_ok;
    assign sts.found       = slot_free && (run_cnt_next == len_reg[CW-1:0]);
    assign sts.last        = (idx_reg == IW'(SLOT_COUNT - 1));

    always_comb
    begin
        map_next = map_reg;
        if (cmd.exec)
        begin
            if (free_ok)
                map_next = map_reg & ~run_mask({1'b0, base_reg}, {1'b0, len_reg});
            else if (func_reg == FUNC_CLEAR)
                map_next = '0;
        end
        else if (cmd.mark)
        begin
            map_next = map_reg | run_mask(SW'(found_base_reg), {1'b0, len_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            map_reg <= '0;
        else
            map_reg <= map_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            base_reg <= base_slot;
            len_reg  <= run_length;
        end
        if (cmd.exec)
        begin
            idx_reg         <= '0;
            run_cnt_reg     <= '0;
            res_granted_reg <= 1'b0;
            res_base_reg    <= '0;
            if (alloc_ok)
                res_status_reg <= ST_NOROOM;
            else if (free_ok || func_reg == FUNC_CLEAR)
                res_status_reg <= ST_DONE;
            else
                res_status_reg <= ST_REJECT;
        end
        if (cmd.step)
        begin
            idx_reg     <= idx_reg + 1'b1;
            run_cnt_reg <= run_cnt_next;
            if (slot_free && run_cnt_reg == '0)
                run_start_reg <= idx_reg;
            if (sts.found)
            begin
                found_base_reg  <= base_now;
                res_granted_reg <= 1'b1;
                res_base_reg    <= GBASE_W'(base_now);
                res_status_reg  <= ST_DONE;
            end
        end
        if (cmd.post)
        begin
            out_granted_reg <= res_granted_reg;
            out_base_reg    <= res_base_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign granted      = out_granted_reg;
    assign granted_base = out_base_reg;
    assign status       = out_status_reg;

endmodule

FILE: hw/rtl/contiguous_slot_allocator_top.sv
// Sequence: free, clear-all and rejected requests pass from acceptance through
//   the exec state to the post state; an allocate also runs the first-fit scan,
//   one slot per cycle, and on a find the mark state, before the post state.
// Throughput: one request at a time; a new request is taken the cycle after
//   the previous result enters the output register, which may still be waiting.
// Reset: rst_n clears the in-use map at once (every slot free) and empties the output.
module contiguous_slot_allocator_top #(
    parameter int SLOT_COUNT = csa_pkg::CSA_SLOT_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [csa_pkg::FUNC_W-1:0]   func,
    input  logic [csa_pkg::BASE_W-1:0]   base_slot,
    input  logic [csa_pkg::LEN_W-1:0]    run_length,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         granted,
    output logic [csa_pkg::GBASE_W-1:0]  granted_base,
    output logic [csa_pkg::STATUS_W-1:0] status
);
    import csa_pkg::*;

    // Command and status link between the sequencer and the datapath
    csa_cmd_t cmd;
    csa_sts_t sts;

    // Sequencer: accept a request, run the scan, post the result
    csa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: in-use map, first-fit scan and the result registers
    csa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (func),
        .base_slot    (base_slot),
        .run_length   (run_length),
        .cmd          (cmd),
        .sts          (sts),
        .granted      (granted),
        .granted_base (granted_base),
        .status       (status)
    );

    // An accepted request always blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after request accept");

    // A granted result carries the done status and a base inside the pool
    a_grant_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && granted) |->
            (status == ST_DONE) && (32'(granted_base) < 32'(SLOT_COUNT)))
        else $error("granted result with bad status or base");

    // A refused or non-allocate result reports base zero
    a_nogrant_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !granted) |-> (granted_base == '0))
        else $error("nonzero base without grant");

    // A result is never posted while a request is still being taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.post) |-> !(cmd.load || cmd.step || cmd.mark || cmd.exec))
        else $error("overlapping datapath commands");

endmodule

FILE: tb/contiguous_slot_allocator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for contiguous_slot_allocator_top: allocate, free and clear-all
// requests are checked against a first-fit slot map kept inside the bench.
// Depends on csa_pkg and the allocator RTL only.
module contiguous_slot_allocator_top_tb;
    import csa_pkg::*;

    localparam int SLOTS           = CSA_SLOT_COUNT;
    localparam int RANDOM_REQUESTS = 1225;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int HOLD_OFF_AFTER  = 300;   // results checked before the long hold-off
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int TAIL_CYCLES     = SLOTS + 8;

    // Opcode 3 has no meaning in the block; it must come back rejected
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_HALF     = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
    } slot_request_t;

    typedef struct packed {
        logic                granted;
        logic [GBASE_W-1:0]  base;
        logic [STATUS_W-1:0] status;
    } slot_grant_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [FUNC_W-1:0]   func;
    logic [BASE_W-1:0]   base_slot;
    logic [LEN_W-1:0]    run_length;
    logic                out_valid;
    logic                out_stall;
    logic                granted;
    logic [GBASE_W-1:0]  granted_base;
    logic [STATUS_W-1:0] status;

    contiguous_slot_allocator_top #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .base_slot   (base_slot),
        .run_length  (run_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .granted     (granted),
        .granted_base(granted_base),
        .status      (status)
    );

    slot_request_t pending_requests[$];   // requests not yet offered
    slot_grant_t   expected_grants[$];    // predicted results, oldest first
    bit [SLOTS-1:0] slots_taken;          // bench copy of the in-use map

    slot_request_t seen_request;
    slot_request_t next_request;
    logic request_taken;                  // request accepted at the last rising edge

    int total_requests = 0;
    int requests_taken = 0;
    int grants_popped  = 0;
    int failures       = 0;
    int cycle_count    = 0;
    int n_granted = 0, n_noroom = 0, n_rejected = 0, n_freed = 0, n_cleared = 0;
    int burst_left = 1, gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = STALL_NONE, mode_left = 0;

    // ------------------------------------------------------------------
    // Clock, cycle counter and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d of %0d requests taken, %0d results",
                 $time, cycle_count, requests_taken, total_requests, grants_popped);
        $display("contiguous_slot_allocator_top_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // First-fit slot map: apply one request to the bench copy of the map
    // and return the result the block must produce for it.
    // ------------------------------------------------------------------
    function automatic slot_grant_t predict_grant(slot_request_t r);
        slot_grant_t g;
        int b;
        int k;
        bit found;
        bit fits;
        g.granted = 1'b0;
        g.base    = '0;
        g.status  = ST_REJECT;
        found     = 1'b0;
        if (r.func == FUNC_ALLOC)
        begin
            // zero length and runs longer than the pool are rejected outright
            if (r.len != 0 && r.len <= SLOTS)
            begin
                g.status = ST_NOROOM;
                // scan bases upward, take the lowest one with a free run
                for (b = 0; b + r.len <= SLOTS && !found; b++)
                begin
                    fits = 1'b1;
                    for (k = 0; k < r.len; k++)
                        if (slots_taken[b + k])
                            fits = 1'b0;
                    if (fits)
                    begin
                        for (k = 0; k < r.len; k++)
                            slots_taken[b + k] = 1'b1;
                        found     = 1'b1;
                        g.granted = 1'b1;
                        g.base    = b[GBASE_W-1:0];
                        g.status  = ST_DONE;
                    end
                end
            end
        end
        else if (r.func == FUNC_FREE)
        begin
            // no partial free: the whole run must lie inside the pool
            if (r.len != 0 && r.base < SLOTS && r.len <= SLOTS - r.base)
            begin
                for (k = 0; k < r.len; k++)
                    slots_taken[r.base + k] = 1'b0;
                g.status = ST_DONE;
            end
        end
        else if (r.func == FUNC_CLEAR)
        begin
            slots_taken = '0;
            g.status    = ST_DONE;
        end
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Compare one result from the block with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_grant();
        slot_grant_t want;
        if (expected_grants.size() == 0)
        begin
            $display("%0t: unexpected result granted=%0d base=%0d status=%0d",
                     $time, granted, granted_base, status);
            failures++;
        end
        else
        begin
            want = expected_grants.pop_front();
            grants_popped++;
            if (granted !== want.granted)
            begin
                $display("%0t: granted expected %0d actual %0d", $time, want.granted, granted);
                failures++;
            end
            if (granted_base !== want.base)
            begin
                $display("%0t: granted_base expected %0d actual %0d",
                         $time, want.base, granted_base);
                failures++;
            end
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                failures++;
            end
            if (want.granted)
                n_granted++;
            else if (want.status == ST_NOROOM)
                n_noroom++;
            else if (want.status == ST_REJECT)
                n_rejected++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Predict on request
    // acceptance, check on result acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_taken <= 1'b0;
            slots_taken = '0;
        end
        else
        begin
            request_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                seen_request = {func, base_slot, run_length};
                expected_grants.push_back(predict_grant(seen_request));
                requests_taken++;
                if (seen_request.func == FUNC_FREE)
                    n_freed++;
                if (seen_request.func == FUNC_CLEAR)
                    n_cleared++;
            end
            if (out_valid && !out_stall)
                check_grant();
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer requests in bursts with random gaps. Hold the payload
    // while the block stalls; advance only after an acceptance.
    // ------------------------------------------------------------------
    task automatic start_burst();
        gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= FUNC_ALLOC;
            base_slot  <= '0;
            run_length <= '0;
        end
        else if (request_taken || !in_valid)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_requests.size() > 0)
            begin
                next_request = pending_requests.pop_front();
                in_valid   <= 1'b1;
                func       <= next_request.func;
                base_slot  <= next_request.base;
                run_length <= next_request.len;
                if (burst_left <= 1)
                    start_burst();
                else
                    burst_left--;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switch among randomly chosen stall patterns, and
    // once hold off for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (!hold_done && grants_popped >= HOLD_OFF_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(STALL_PERIODIC, STALL_NONE);
                mode_left  = $urandom_range(300, 50);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_HALF:  out_stall <= ($urandom_range(1, 0) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(9, 0) < 8);
                default:     out_stall <= (cycle_count % 3 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_request(logic [FUNC_W-1:0] f, int b, int n);
        slot_request_t r;
        r.func = f;
        r.base = b[BASE_W-1:0];
        r.len  = n[LEN_W-1:0];
        pending_requests.push_back(r);
    endtask

    // Mostly well-formed allocate/free traffic with random sizes, plus some
    // clears, malformed requests and pure noise.
    task automatic queue_random_request();
        int sel;
        int b;
        sel = $urandom_range(99, 0);
        if (sel < 45)
        begin
            queue_request(FUNC_ALLOC, $urandom_range(255, 0), $urandom_range(6, 1));
        end
        else if (sel < 50)
        begin
            queue_request(FUNC_ALLOC, $urandom_range(255, 0), $urandom_range(SLOTS, 7));
        end
        else if (sel < 78)
        begin
            b = $urandom_range(SLOTS - 1, 0);
            queue_request(FUNC_FREE, b, $urandom_range((SLOTS - b < 8) ? SLOTS - b : 8, 1));
        end
        else if (sel < 81)
        begin
            queue_request(FUNC_CLEAR, $urandom_range(255, 0), $urandom_range(255, 0));
        end
        else if (sel < 86)
        begin
            // zero length or longer than the pool
            queue_request(FUNC_ALLOC, $urandom_range(255, 0),
                          $urandom_range(1, 0) ? 0 : $urandom_range(255, SLOTS + 1));
        end
        else if (sel < 91)
        begin
            // base outside the pool, or a run that overruns its top
            if ($urandom_range(1, 0))
            begin
                queue_request(FUNC_FREE, $urandom_range(255, SLOTS), $urandom_range(255, 0));
            end
            else
            begin
                b = $urandom_range(SLOTS - 1, 0);
                queue_request(FUNC_FREE, b, $urandom_range(255, SLOTS - b + 1));
            end
        end
        else
        begin
            queue_request(FUNC_W'($urandom_range(3, 0)), $urandom_range(255, 0),
                          $urandom_range(255, 0));
        end
    endtask

    initial
    begin : stimulus
        int i;
        rst_n      = 1'b0;

        // Directed: rejected allocate sizes, whole-pool allocate, pool full
        queue_request(FUNC_ALLOC, 0, 0);
        queue_request(FUNC_ALLOC, 0, SLOTS + 1);
        queue_request(FUNC_ALLOC, 255, 255);
        queue_request(FUNC_ALLOC, 0, SLOTS);
        queue_request(FUNC_ALLOC, 0, 1);
        queue_request(FUNC_FREE, 0, SLOTS);
        // First fit: open a hole too small for the next run, then fill it
        queue_request(FUNC_ALLOC, 0, 3);
        queue_request(FUNC_ALLOC, 0, 5);
        queue_request(FUNC_ALLOC, 0, 2);
        queue_request(FUNC_FREE, 3, 5);
        queue_request(FUNC_ALLOC, 0, 6);
        queue_request(FUNC_ALLOC, 0, 4);
        // Free outside the pool, overrunning it, zero length, already free
        queue_request(FUNC_FREE, SLOTS, 1);
        queue_request(FUNC_FREE, 255, 255);
        queue_request(FUNC_FREE, SLOTS - 1, 2);
        queue_request(FUNC_FREE, 30, 0);
        queue_request(FUNC_FREE, SLOTS - 1, 1);
        queue_request(FUNC_FREE, 8'hAA, 8'h55);
        // Unused opcode, clear-all with junk arguments
        queue_request(FUNC_UNUSED, 8'h55, 8'hAA);
        queue_request(FUNC_CLEAR, 255, 255);
        // Run that ends exactly at the top slot
        queue_request(FUNC_ALLOC, 0, 1);
        queue_request(FUNC_ALLOC, 0, SLOTS - 1);
        queue_request(FUNC_ALLOC, 0, 1);
        queue_request(FUNC_FREE, 1, SLOTS - 1);
        queue_request(FUNC_CLEAR, 0, 0);

        for (i = 0; i < RANDOM_REQUESTS; i++)
            queue_random_request();
        total_requests = pending_requests.size();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every request taken, every prediction checked, then a short tail
        wait (requests_taken == total_requests && grants_popped == total_requests);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_grants.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_grants.size());
            failures++;
        end

        $display("%0d requests: %0d granted, %0d no room, %0d rejected, %0d frees, %0d clears",
                 requests_taken, n_granted, n_noroom, n_rejected, n_freed, n_cleared);
        $display("%0d mismatches in %0d cycles", failures, cycle_count);
        if (failures == 0)
            $display("contiguous_slot_allocator_top_tb OK");
        else
            $display("contiguous_slot_allocator_top_tb NOT OK");
        $finish;
    end

endmodule
